// ----- sv/swst_pkg.sv -----
// Shared types and constants for the sliding window statistics block.
`default_nettype none
package swst_pkg;

  // Width of the window size register.
  localparam int CFG_BITS = 5;
  // Window size after reset.
  localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd4;

  // Controls for the window cells: fill all, shift in a sample, or rotate.
  typedef struct packed {
    logic fill;
    logic shift;
    logic rot;
  } swst_win_ctrl_t;

  // Controls for the sorting cells.
  typedef struct packed {
    logic clear;
  } swst_sort_ctrl_t;

endpackage
`default_nettype wire

// ----- sv/swst_if.sv -----
// Valid/ready channel interfaces for samples in and statistics out.
`default_nettype none
interface swst_in_if #(
  parameter int SB = 16
) ();
  logic          valid;
  logic          ready;
  logic [SB-1:0] sample;
  logic          start_of_stream;

  modport source(output valid, sample, start_of_stream, input ready);
  modport sink(input valid, sample, start_of_stream, output ready);
endinterface

interface swst_out_if #(
  parameter int SB = 16
) ();
  logic          valid;
  logic          ready;
  logic [SB-1:0] window_min;
  logic [SB-1:0] window_max;
  logic [SB+7:0] window_mean;
  logic [SB:0]   window_median_x2;
  logic [SB+7:0] window_std_dev;

  modport source(output valid, window_min, window_max, window_mean, window_median_x2,
                 window_std_dev, input ready);
  modport sink(input valid, window_min, window_max, window_mean, window_median_x2,
               window_std_dev, output ready);
endinterface
`default_nettype wire

// ----- sv/swst_win_cell.sv -----
// One window cell: holds one sample and passes it along the ring.
`default_nettype none
module swst_win_cell #(
  parameter int SB = 16
) (
  input  wire logic                    clk,
  input  wire swst_pkg::swst_win_ctrl_t ctrl,
  input  wire logic [SB-1:0]           fill_val,
  input  wire logic [SB-1:0]           prev_val,
  input  wire logic [SB-1:0]           succ_val,
  output logic [SB-1:0]                val
);
  import swst_pkg::*;

  // Fill on a stream start, shift toward older on a new sample, rotate during a scan.
  always_ff @(posedge clk) begin
    if (ctrl.fill) begin
      val <= fill_val;
    end else if (ctrl.shift) begin
      val <= prev_val;
    end else if (ctrl.rot) begin
      val <= succ_val;
    end
  end
endmodule
`default_nettype wire

// ----- sv/swst_sort_cell.sv -----
// One cell of a systolic insertion sorter: keeps the smallest value it has seen.
`default_nettype none
module swst_sort_cell #(
  parameter int SB = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire swst_pkg::swst_sort_ctrl_t ctrl,
  input  wire logic                     in_valid,
  input  wire logic [SB-1:0]            in_data,
  output logic                          pass_valid,
  output logic [SB-1:0]                 pass_data,
  output logic [SB-1:0]                 held
);
  import swst_pkg::*;

  logic held_valid;

  // Keep the smaller value and hand the larger one to the next cell.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      held_valid <= 1'b0;
      pass_valid <= 1'b0;
    end else if (in_valid) begin
      if (!held_valid) begin
        held       <= in_data;
        held_valid <= 1'b1;
        pass_valid <= 1'b0;
      end else if ($signed(in_data) < $signed(held)) begin
        held       <= in_data;
        pass_data  <= held;
        pass_valid <= 1'b1;
      end else begin
        pass_data  <= in_data;
        pass_valid <= 1'b1;
      end
    end else begin
      pass_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ----- sv/swst_div.sv -----
// Restoring divider: one quotient bit per cycle.
`default_nettype none
module swst_div #(
  parameter int WD = 64,
  parameter int WS = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [WD-1:0] dividend,
  input  wire logic [WS-1:0] divisor,
  output logic               done,
  output logic [WD-1:0]      quotient
);
  localparam int CW = $clog2(WD + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [WS-1:0] rem;
  logic [WS-1:0] dsr;
  logic [WS:0]   trial;
  logic          take;

  assign trial = {rem, quotient[WD-1]};
  assign take  = trial >= {1'b0, dsr};

  // Control: count the quotient bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(WD - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift the dividend through, subtracting where it fits.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dsr      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      rem      <= take ? WS'(trial - {1'b0, dsr}) : WS'(trial);
      quotient <= {quotient[WD-2:0], take};
    end
  end
endmodule
`default_nettype wire

// ----- sv/swst_sqrt.sv -----
// Digit-by-digit integer square root: one root bit per cycle.
`default_nettype none
module swst_sqrt #(
  parameter int WR = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [WR-1:0]   radicand,
  output logic                 done,
  output logic [WR/2-1:0]      root
);
  localparam int WH = WR / 2;
  localparam int CW = $clog2(WH + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [WR-1:0] rad;
  logic [WH+2:0] rem;
  logic [WH+2:0] remsh;
  logic [WH+2:0] trial;
  logic          take;

  assign remsh = {rem[WH:0], rad[WR-1:WR-2]};
  assign trial = {1'b0, root, 2'b01};
  assign take  = remsh >= trial;

  // Control: count the root bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(WH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: bring down two radicand bits and try the next root bit.
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[WR-3:0], 2'b00};
      rem  <= take ? remsh - trial : remsh;
      root <= {root[WH-2:0], take};
    end
  end
endmodule
`default_nettype wire

// ----- sv/sliding_window_statistics.sv -----
// Top level of the sliding window statistics block.
//
// Usage: samples arrive on the samples channel (sample, start_of_stream), one
// statistics request leaves on the stats channel for each sample: minimum,
// maximum, mean times 256, twice the median and the sample standard deviation
// times 256. The window size is to be written through wr_en/wr_data only while
// idle; the block itself does not enforce this. A sample is scanned by rotating
// the ring of window cells once while it feeds the sorting cells, which then
// settle. A bit-serial divider computes the mean and then the variance, one
// iteration per bit of its 2*SAMPLE_BITS+2*ceil(log2(WINDOW_MAX+1))+16-bit
// quotient, and a bit-serial square root follows with one iteration per bit of
// the root, which is half as wide. One sample is processed at a time.
// Reset clears the control state and sets the window size to 4; the first
// sample after reset fills the whole window. If the receiver stalls, the
// result waits in the output register; the next sample is still accepted and
// computed, and its result waits until the output register is free.
`default_nettype none
module sliding_window_statistics #(
  parameter int WINDOW_MAX  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         wr_en,
  input  wire logic [swst_pkg::CFG_BITS-1:0] wr_data,
  swst_in_if.sink                           samples,
  swst_out_if.source                        stats
);
  import swst_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int NB  = $clog2(WINDOW_MAX + 1);
  localparam int IB  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SW  = SB + NB;
  localparam int QSW = 2 * SB + NB;
  localparam int DW  = 2 * SB + 2 * NB;
  localparam int QW  = DW + 16;
  localparam int MW  = 2 * NB;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SCAN    = 4'd1;
  localparam logic [3:0] ST_SETTLE  = 4'd2;
  localparam logic [3:0] ST_PREP    = 4'd3;
  localparam logic [3:0] ST_DIVM    = 4'd4;
  localparam logic [3:0] ST_DIVV_GO = 4'd5;
  localparam logic [3:0] ST_DIVV    = 4'd6;
  localparam logic [3:0] ST_SQRT_GO = 4'd7;
  localparam logic [3:0] ST_SQRT    = 4'd8;
  localparam logic [3:0] ST_LOAD    = 4'd9;

  logic [3:0]          state;
  logic [3:0]          state_next;
  logic [IB-1:0]       cnt;
  logic [CFG_BITS-1:0] wsize;
  logic                primed;
  logic [NB-1:0]       n;
  logic                accept;
  logic                fill_all;

  logic [SB-1:0]       win [WINDOW_MAX];
  logic [SB-1:0]       srt [WINDOW_MAX];
  logic                pv  [WINDOW_MAX];
  logic [SB-1:0]       pd  [WINDOW_MAX];
  swst_win_ctrl_t      wctrl;
  swst_sort_ctrl_t     sctrl;
  logic                feed;

  logic signed [SB-1:0]   cur;
  logic signed [2*SB-1:0] sq;
  logic signed [SB-1:0]   mn;
  logic signed [SB-1:0]   mx;
  logic signed [SW-1:0]   sum;
  logic [QSW-1:0]         sumsq;
  logic [DW-1:0]          pa;
  logic [DW-1:0]          pb;
  logic signed [2*SW-1:0] sum_sq;
  logic [SW-1:0]          sum_mag;
  logic                   mean_neg;
  logic [SB+7:0]          mean;

  logic          div_start;
  logic [QW-1:0] div_dvd;
  logic [MW-1:0] div_dsr;
  logic          div_done;
  logic [QW-1:0] div_q;
  logic          sq_done;
  logic [QW/2-1:0] root;

  logic [IB-1:0]        mid;
  logic signed [SB:0]   med;

  assign accept       = samples.valid && samples.ready;
  assign samples.ready = (state == ST_IDLE);
  assign fill_all     = samples.start_of_stream || !primed;

  // Clamp the window size into the supported range.
  always_comb begin
    if (wsize < CFG_BITS'(2)) begin
      n = NB'(2);
    end else if (32'(wsize) > WINDOW_MAX) begin
      n = NB'(WINDOW_MAX);
    end else begin
      n = NB'(wsize);
    end
  end

  // Configuration register and stream-start tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      wsize  <= CFG_RESET;
      primed <= 1'b0;
    end else begin
      if (wr_en) begin
        wsize <= wr_data;
      end
      if (accept) begin
        primed <= 1'b1;
      end
    end
  end

  // Ring of window cells; cell 0 holds the newest sample.
  assign wctrl.fill  = accept && fill_all;
  assign wctrl.shift = accept && !fill_all;
  assign wctrl.rot   = (state == ST_SCAN);

  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_win
    swst_win_cell #(.SB(SB)) u_cell (
      .clk      (clk),
      .ctrl     (wctrl),
      .fill_val (samples.sample),
      .prev_val ((k == 0) ? samples.sample : win[(k + WINDOW_MAX - 1) % WINDOW_MAX]),
      .succ_val (win[(k + 1) % WINDOW_MAX]),
      .val      (win[k])
    );
  end

  // Chain of sorting cells fed from the head of the ring during the scan.
  assign sctrl.clear = accept;
  assign feed        = (state == ST_SCAN) && (NB'(cnt) < n);

  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_sort
    swst_sort_cell #(.SB(SB)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (sctrl),
      .in_valid   ((k == 0) ? feed : pv[(k + WINDOW_MAX - 1) % WINDOW_MAX]),
      .in_data    ((k == 0) ? win[0] : pd[(k + WINDOW_MAX - 1) % WINDOW_MAX]),
      .pass_valid (pv[k]),
      .pass_data  (pd[k]),
      .held       (srt[k])
    );
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (accept) state_next = ST_SCAN;
      ST_SCAN:    if (cnt == IB'(WINDOW_MAX - 1)) state_next = ST_SETTLE;
      ST_SETTLE:  if (cnt == IB'(WINDOW_MAX - 1)) state_next = ST_PREP;
      ST_PREP:    state_next = ST_DIVM;
      ST_DIVM:    if (div_done) state_next = ST_DIVV_GO;
      ST_DIVV_GO: state_next = ST_DIVV;
      ST_DIVV:    if (div_done) state_next = ST_SQRT_GO;
      ST_SQRT_GO: state_next = ST_SQRT;
      ST_SQRT:    if (sq_done) state_next = ST_LOAD;
      ST_LOAD:    if (!stats.valid || stats.ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SCAN || state == ST_SETTLE) begin
        cnt <= (cnt == IB'(WINDOW_MAX - 1)) ? '0 : cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  // Accumulate minimum, maximum, sum and sum of squares during the scan.
  assign cur = $signed(win[0]);
  assign sq  = cur * cur;

  always_ff @(posedge clk) begin
    if (feed) begin
      if (cnt == '0) begin
        mn    <= cur;
        mx    <= cur;
        sum   <= SW'(cur);
        sumsq <= QSW'($unsigned(sq));
      end else begin
        if (cur < mn) mn <= cur;
        if (cur > mx) mx <= cur;
        sum   <= sum + SW'(cur);
        sumsq <= sumsq + QSW'($unsigned(sq));
      end
    end
  end

  // Pairwise squared differences as n*sum(x^2) - sum(x)^2.
  assign sum_sq  = sum * sum;
  assign sum_mag = sum[SW-1] ? SW'(-sum) : SW'(sum);

  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      pa       <= DW'(sumsq) * DW'(n);
      pb       <= DW'($unsigned(sum_sq));
      mean_neg <= sum[SW-1];
    end
  end

  // Shared divider: mean first, then variance.
  assign div_start = (state == ST_PREP) || (state == ST_DIVV_GO);
  assign div_dvd   = (state == ST_PREP) ? QW'({sum_mag, 8'h00}) : QW'({pa - pb, 16'h0000});
  assign div_dsr   = (state == ST_PREP) ? MW'(n) : MW'(n) * MW'(n - 1'b1);

  swst_div #(.WD(QW), .WS(MW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (state == ST_DIVM && div_done) begin
      mean <= mean_neg ? (SB + 8)'(-div_q[SB+7:0]) : div_q[SB+7:0];
    end
  end

  swst_sqrt #(.WR(QW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_SQRT_GO),
    .radicand (div_q),
    .done     (sq_done),
    .root     (root)
  );

  // Median from the sorted cells.
  assign mid = IB'(n >> 1);
  always_comb begin
    if (n[0]) begin
      med = {srt[mid][SB-1], srt[mid]} + {srt[mid][SB-1], srt[mid]};
    end else begin
      med = {srt[mid - 1'b1][SB-1], srt[mid - 1'b1]} + {srt[mid][SB-1], srt[mid]};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stats.valid <= 1'b0;
    end else if (state == ST_LOAD && (!stats.valid || stats.ready)) begin
      stats.valid <= 1'b1;
    end else if (stats.ready) begin
      stats.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD && (!stats.valid || stats.ready)) begin
      stats.window_min       <= mn;
      stats.window_max       <= mx;
      stats.window_mean      <= mean;
      stats.window_median_x2 <= med;
      stats.window_std_dev   <= root[SB+7:0];
    end
  end

  // A request starts a scan from the head of the ring.
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SCAN) && (cnt == '0))
    else $error("request did not start a scan");

  // The reported minimum never exceeds the maximum.
  a_min_max: assert property (@(posedge clk) disable iff (rst)
    $rose(stats.valid) |-> ($signed(stats.window_min) <= $signed(stats.window_max)))
    else $error("minimum above maximum");

  // The doubled median lies between twice the minimum and twice the maximum.
  a_median: assert property (@(posedge clk) disable iff (rst)
    $rose(stats.valid) |->
      ($signed(stats.window_median_x2) >= $signed({stats.window_min, 1'b0})) &&
      ($signed(stats.window_median_x2) <= $signed({stats.window_max, 1'b0})))
    else $error("median outside window range");

endmodule
`default_nettype wire

// ----- tb/sliding_window_statistics_test.sv -----
// Self-checking testbench for the sliding window statistics block.
`timescale 1ns / 100ps
`default_nettype none
module sliding_window_statistics_test;
  import swst_pkg::*;

  localparam int WIN_DEPTH = 16;
  localparam int N_RANDOM = 930;
  localparam int LATENCY = 400;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               start_of_stream;
  } sample_req_t;

  typedef struct packed {
    logic [15:0] wmin;
    logic [15:0] wmax;
    logic [23:0] wmean;
    logic [16:0] wmed2;
    logic [23:0] wstd;
  } stats_req_t;

  logic clk;
  logic rst;
  logic wr_en;
  logic [CFG_BITS-1:0] wr_data;

  swst_in_if #(.SB(16)) samples ();
  swst_out_if #(.SB(16)) stats ();

  sliding_window_statistics dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_data(wr_data),
    .samples(samples.sink), .stats(stats.source)
  );

  // Predictor state: window contents, write pointer and the size register.
  logic [CFG_BITS-1:0] win_size_reg;
  logic signed [15:0]  win_cells [WIN_DEPTH];
  int unsigned         win_ptr;
  bit                  win_primed;

  sample_req_t pending_samples[$];
  stats_req_t  expected_stats[$];
  int   n_accepted, n_results, n_mismatch;
  bit   fail_seen;
  bit   hold_off;
  bit   idle_free;
  bit   in_taken;

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Update the window with one sample and work out its statistics.
  function automatic stats_req_t window_stats(sample_req_t req);
    stats_req_t res;
    longint v[WIN_DEPTH];
    longint mn, mx, sum, mean, t, med2;
    longint unsigned d, m, var_q, df;
    int n, k, j, newest;
    n = int'(win_size_reg);
    if (n < 2) n = 2;
    if (n > WIN_DEPTH) n = WIN_DEPTH;
    if (req.start_of_stream || !win_primed) begin
      for (k = 0; k < WIN_DEPTH; k++) win_cells[k] = req.sample;
      win_primed = 1;
    end else begin
      win_cells[win_ptr] = req.sample;
    end
    newest = win_ptr;
    win_ptr = (win_ptr + 1) % WIN_DEPTH;
    for (k = 0; k < n; k++)
      v[k] = longint'(win_cells[(newest + WIN_DEPTH - k) % WIN_DEPTH]);
    mn = v[0];
    mx = v[0];
    sum = 0;
    for (k = 0; k < n; k++) begin
      if (v[k] < mn) mn = v[k];
      if (v[k] > mx) mx = v[k];
      sum += v[k];
    end
    mean = (sum * 256) / n;
    d = 0;
    for (k = 0; k < n; k++)
      for (j = k + 1; j < n; j++) begin
        df = (v[k] >= v[j]) ? v[k] - v[j] : v[j] - v[k];
        d += df * df;
      end
    m = 64'(n * (n - 1));
    var_q = (d / m) * 65536 + ((d % m) * 65536) / m;
    // Insertion sort for the median.
    for (k = 1; k < n; k++) begin
      t = v[k];
      j = k;
      while (j > 0 && v[j-1] > t) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = t;
    end
    med2 = (n % 2 == 0) ? v[n/2-1] + v[n/2] : 2 * v[n/2];
    res.wmin = mn[15:0];
    res.wmax = mx[15:0];
    res.wmean = mean[23:0];
    res.wmed2 = med2[16:0];
    res.wstd = 24'(floor_sqrt(var_q));
    return res;
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Note at each rising edge whether the offered request was taken.
  always @(posedge clk) begin
    in_taken = samples.valid && samples.ready;
  end

  // Driver: offers queued requests, with random gaps.
  always @(negedge clk) begin
    if (rst) begin
      samples.valid <= 0;
      samples.sample <= '0;
      samples.start_of_stream <= 0;
    end else if (samples.valid && !in_taken) begin
      // Hold the current request until it is taken.
    end else if (pending_samples.size() != 0 && (idle_free || $urandom_range(99) >= 20)) begin
      samples.valid <= 1;
      samples.sample <= pending_samples[0].sample;
      samples.start_of_stream <= pending_samples[0].start_of_stream;
      void'(pending_samples.pop_front());
    end else begin
      samples.valid <= 0;
    end
  end

  // Receiver readiness: random stalls, or a long hold-off when asked.
  always @(negedge clk) begin
    if (rst) stats.ready <= 0;
    else stats.ready <= !hold_off && (idle_free || $urandom_range(99) >= 20);
  end

  // Monitor: predict on accepted samples, check on accepted results.
  always @(posedge clk) begin
    if (!rst) begin
      if (samples.valid && samples.ready) begin
        expected_stats.push_back(window_stats({samples.sample, samples.start_of_stream}));
        n_accepted++;
      end
      if (stats.valid && stats.ready) begin
        n_results++;
        if (expected_stats.size() == 0) begin
          fail_seen = 1;
          n_mismatch++;
          if (n_mismatch <= 10) $display("result with no request pending");
        end else begin
          if (expected_stats[0] !== {stats.window_min, stats.window_max, stats.window_mean,
                                     stats.window_median_x2, stats.window_std_dev}) begin
            fail_seen = 1;
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("mismatch: exp min %h max %h mean %h med2 %h std %h, got %h %h %h %h %h",
                expected_stats[0].wmin, expected_stats[0].wmax, expected_stats[0].wmean,
                expected_stats[0].wmed2, expected_stats[0].wstd, stats.window_min,
                stats.window_max, stats.window_mean, stats.window_median_x2,
                stats.window_std_dev);
          end
          void'(expected_stats.pop_front());
        end
      end
    end
  end

  task automatic push_sample(logic [15:0] s, logic sos);
    pending_samples.push_back({s, sos});
  endtask

  // Drain everything, then wait out the latency before touching the register.
  task automatic drain_all();
    wait (pending_samples.size() == 0);
    @(posedge clk);
    while (samples.valid || expected_stats.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_size(logic [CFG_BITS-1:0] v);
    @(negedge clk);
    wr_en <= 1;
    wr_data <= v;
    @(negedge clk);
    wr_en <= 0;
    win_size_reg = v;
  endtask

  // Random sample: half full range, the rest near extremes or a small cluster.
  function automatic logic [15:0] rand_sample();
    case ($urandom_range(3))
      0: return 16'($urandom_range(7) - 4);
      1: return $urandom_range(1) ? 16'(16'h7FFF - $urandom_range(3))
                                  : 16'(16'h8000 + $urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [CFG_BITS-1:0] sizes[8];
    sizes = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd1, 5'd7, 5'd17, 5'd9};
    rst = 1;
    wr_en = 0;
    wr_data = '0;
    hold_off = 0;
    idle_free = 0;
    win_size_reg = CFG_RESET;
    win_ptr = 0;
    win_primed = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: first item without start acts as a start, extremes, mid-stream restart.
    push_sample(16'h8000, 0);
    push_sample(16'h7FFF, 0);
    push_sample(16'h8000, 0);
    push_sample(16'h7FFF, 0);
    push_sample(16'h0000, 0);
    push_sample(16'hFFFF, 1);
    push_sample(16'h0001, 0);
    push_sample(16'h5555, 0);
    push_sample(16'hAAAA, 0);
    drain_all();
    write_size(5'd16);
    push_sample(16'h7FFF, 1);
    for (int i = 0; i < 8; i++) push_sample(i[0] ? 16'h8000 : 16'h7FFF, 0);
    drain_all();

    // Random phases over several window sizes, including out-of-range codes.
    for (int p = 0; p < 8; p++) begin
      write_size(sizes[p]);
      idle_free = (p == 3);
      for (int i = 0; i < N_RANDOM / 8; i++)
        push_sample(rand_sample(), $urandom_range(39) == 0);
      // Long receiver hold-off so the block fills and backs up its input.
      if (p == 1) begin
        repeat (5) @(negedge clk);
        hold_off = 1;
        repeat (2000) @(negedge clk);
        hold_off = 0;
      end
      drain_all();
    end
    $display("tb: %0d samples sent, %0d results checked, window sizes 2..16 and out-of-range",
             n_accepted, n_results);
    if (!fail_seen && expected_stats.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
